// File: hdl/tll_pkg.sv
// Shared types, constants and character helpers of the toy language lexer.
`default_nettype none

package tll_pkg;

    localparam int MAX_LEXEME = 32;
    localparam int LEN_W      = $clog2(MAX_LEXEME + 1);
    localparam int AW         = $clog2(MAX_LEXEME);
    localparam int KIND_W     = 5;
    localparam int KW_NUM     = 6;

    localparam logic [KIND_W-1:0] K_PRINT  = 5'd0;
    localparam logic [KIND_W-1:0] K_ID     = 5'd6;
    localparam logic [KIND_W-1:0] K_INT    = 5'd7;
    localparam logic [KIND_W-1:0] K_STR    = 5'd8;
    localparam logic [KIND_W-1:0] K_PLUS   = 5'd9;
    localparam logic [KIND_W-1:0] K_MINUS  = 5'd10;
    localparam logic [KIND_W-1:0] K_STAR   = 5'd11;
    localparam logic [KIND_W-1:0] K_SLASH  = 5'd12;
    localparam logic [KIND_W-1:0] K_BANG   = 5'd13;
    localparam logic [KIND_W-1:0] K_LPAREN = 5'd14;
    localparam logic [KIND_W-1:0] K_RPAREN = 5'd15;
    localparam logic [KIND_W-1:0] K_SC     = 5'd16;
    localparam logic [KIND_W-1:0] K_ERR    = 5'd17;
    localparam logic [KIND_W-1:0] K_DONE   = 5'd18;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;

    // Keyword text, padded to eight positions so that any 3-bit index is in range.
    localparam logic [7:0] KW_TEXT [KW_NUM][8] = '{
        '{"P", "R", "I", "N", "T", 8'h00, 8'h00, 8'h00},
        '{"L", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"I", "F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"L", "O", "O", "P", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"B", "E", "G", "I", "N", 8'h00, 8'h00, 8'h00},
        '{"E", "N", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [LEN_W-1:0] KW_LEN [KW_NUM] = '{
        LEN_W'(5), LEN_W'(3), LEN_W'(2), LEN_W'(4), LEN_W'(5), LEN_W'(3)
    };

    typedef enum logic [2:0] {
        MODE_BEGIN   = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_INT     = 3'd2,
        MODE_STR     = 3'd3,
        MODE_ESC     = 3'd4,
        MODE_SLASH   = 3'd5,
        MODE_COMMENT = 3'd6
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_STRC, S_BEGINC, S_EMIT, S_QUOTE,
        S_EMPTY, S_RD, S_OUT, S_SINGLE, S_DONE
    } state_t;

    typedef struct packed {
        logic       command;
        logic [7:0] char_in;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] token_kind;
        logic              has_char;
        logic [7:0]        lexeme_char;
        logic              last_of_token;
        logic [15:0]       line_number;
        logic              truncated;
    } out_item_t;

    typedef struct packed {
        logic              app;
        logic [7:0]        app_char;
        logic              clr;
        logic              line_up;
        logic              rd_clr;
        logic              rd_inc;
        logic              out_load;
        logic              out_has;
        logic              out_from_ram;
        logic [7:0]        out_char;
        logic [KIND_W-1:0] out_kind;
        logic              out_last;
        logic              out_trunc;
    } dp_cmd_t;

    typedef struct packed {
        logic              out_free;
        logic              len_zero;
        logic              rd_last;
        logic              ovf;
        logic [KIND_W-1:0] kw_kind;
    } dp_stat_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_esc_lit(input logic [7:0] c);
        return (c >= 8'd9 && c <= 8'd13) || (c >= 8'd32 && c <= 8'd126 && !is_digit(c));
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

endpackage

`default_nettype wire

// File: hdl/toy_language_lexer.sv
// Top level of the toy language lexer: controller and datapath.
`default_nettype none

// The lexer takes one item at a time: a character byte, or an end-of-input
// mark, and turns the stream into tokens, one result item per lexeme
// character (or a single item with no character for an empty lexeme). An item
// that yields no result passes through acceptance and decode only. A token
// held in the lexeme buffer is then read out of a 32-entry RAM with a
// registered read port, each character through a read state and an output
// state, after a state that starts the readout. A leading quote on an
// unterminated string, a single-character token, an empty lexeme and DONE
// each have an output state of their own; every output state waits while the
// output register is stalled. A token ended by a character that is not its
// own is followed by a further decode step that rescans that character, and
// so does a backslash that turns out literal inside a string. The output
// register lets the controller move on while the last result waits. The line
// counter resets to 1 and is loaded with cfg_data by a configuration write.
module toy_language_lexer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire tll_pkg::in_item_t in_item,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output tll_pkg::out_item_t     out_item,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [15:0]       cfg_data
);
    import tll_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Scanner modes and sequencing live in the controller.
    tll_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Buffer, keyword match, line count and the result register.
    tll_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

// File: hdl/tll_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hdl/tll_dpath.sv
// Lexer datapath: lexeme buffer, keyword tracking, line counter and output register.
`default_nettype none

module tll_dpath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tll_pkg::dp_cmd_t    cmd,
    output tll_pkg::dp_stat_t        stat,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [15:0]         cfg_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output tll_pkg::out_item_t       out_item
);
    import tll_pkg::*;

    logic [LEN_W-1:0]  len_reg, len_next, base_len;
    logic              ovf_reg, ovf_next;
    logic [KW_NUM-1:0] match_reg, match_next, base_match;
    logic [15:0]       line_reg;
    logic [LEN_W-1:0]  rd_reg;
    logic              out_valid_reg;
    out_item_t         out_item_reg;
    logic              ram_we;
    logic [7:0]        ram_rdata;
    logic [7:0]        up_char;
    logic [KIND_W-1:0] kw_kind;

    tll_ram #(.WIDTH(8), .DEPTH(MAX_LEXEME)) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (base_len[AW-1:0]),
        .wdata (cmd.app_char),
        .raddr (rd_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // A clear and an append in the same cycle start a new lexeme with that character.
    always_comb
    begin
        base_len   = cmd.clr ? '0 : len_reg;
        base_match = cmd.clr ? '1 : match_reg;
        ovf_next   = cmd.clr ? 1'b0 : ovf_reg;
        len_next   = base_len;
        match_next = base_match;
        ram_we     = 1'b0;
        up_char    = to_upper(cmd.app_char);
        if (cmd.app)
        begin
            if (base_len < LEN_W'(MAX_LEXEME))
            begin
                ram_we   = 1'b1;
                len_next = base_len + LEN_W'(1);
                for (int k = 0; k < KW_NUM; k++)
                begin
                    match_next[k] = base_match[k] && (base_len < KW_LEN[k])
                                    && (up_char == KW_TEXT[k][base_len[2:0]]);
                end
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        kw_kind = K_ID;
        if (!ovf_reg)
        begin
            for (int k = KW_NUM - 1; k >= 0; k--)
            begin
                if (match_reg[k] && len_reg == KW_LEN[k])
                begin
                    kw_kind = KIND_W'(k);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            match_reg     <= '1;
            line_reg      <= 16'd1;
            rd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            match_reg <= match_next;
            if (cfg_valid)
            begin
                line_reg <= cfg_data;
            end
            else if (cmd.line_up && line_reg != 16'hFFFF)
            begin
                line_reg <= line_reg + 16'd1;
            end
            if (cmd.rd_clr)
            begin
                rd_reg <= '0;
            end
            else if (cmd.rd_inc)
            begin
                rd_reg <= rd_reg + LEN_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_item_reg.token_kind    <= cmd.out_kind;
            out_item_reg.has_char      <= cmd.out_has;
            out_item_reg.lexeme_char   <= !cmd.out_has ? 8'd0 :
                                          cmd.out_from_ram ? ram_rdata : cmd.out_char;
            out_item_reg.last_of_token <= cmd.out_last;
            out_item_reg.line_number   <= line_reg;
            out_item_reg.truncated     <= cmd.out_trunc;
        end
    end

    assign stat.out_free = !out_valid_reg || !out_stall;
    assign stat.len_zero = (len_reg == '0);
    assign stat.rd_last  = ((rd_reg + LEN_W'(1)) == len_reg);
    assign stat.ovf      = ovf_reg;
    assign stat.kw_kind  = kw_kind;
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign out_item      = out_item_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_LEXEME))
        else $error("lexeme length beyond buffer");
    a_no_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_item_reg.has_char |-> out_item_reg.lexeme_char == 8'd0)
        else $error("result without character carries a character");
    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.token_kind == K_DONE
        |-> out_item_reg.last_of_token && !out_item_reg.truncated)
        else $error("malformed DONE result");
    a_ram_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_inc |-> rd_reg < len_reg)
        else $error("buffer read beyond lexeme");

endmodule

`default_nettype wire

// File: hdl/tll_ctrl.sv
// Lexer controller: scanner mode, item decode and token emission sequencing.
`default_nettype none

module tll_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire tll_pkg::in_item_t in_item,
    output tll_pkg::dp_cmd_t       cmd,
    input  wire tll_pkg::dp_stat_t stat
);
    import tll_pkg::*;

    typedef enum logic [2:0] {ACT_NONE, ACT_EMIT, ACT_SINGLE, ACT_STRC, ACT_DONE} act_t;

    typedef struct packed {
        logic              app;
        logic [7:0]        app_char;
        logic              clr;
        logic              line_up;
        logic              set_mode;
        mode_t             mode;
        act_t              act;
        logic [KIND_W-1:0] kind;
        logic              quote;
        logic [7:0]        ch;
        state_t            after;
    } plan_t;

    state_t            state_reg, state_next, after_reg, after_next;
    mode_t             mode_reg, mode_next;
    logic              cmd_reg, cmd_next, quote_reg, quote_next;
    logic [7:0]        ch_reg, ch_next, sch_reg, sch_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    plan_t             plan;

    function automatic plan_t plan_init();
        plan_t p;
        p          = '0;
        p.mode     = MODE_BEGIN;
        p.act      = ACT_NONE;
        p.after    = S_IDLE;
        return p;
    endfunction

    function automatic plan_t begin_plan(input logic [7:0] c);
        plan_t p;
        p          = plan_init();
        p.clr      = 1'b1;
        p.set_mode = 1'b1;
        p.ch       = c;
        if (is_letter(c))
        begin
            p.app = 1'b1; p.app_char = c; p.mode = MODE_IDENT;
        end
        else if (is_digit(c))
        begin
            p.app = 1'b1; p.app_char = c; p.mode = MODE_INT;
        end
        else
        begin
            unique case (c)
                CH_QUOTE:  p.mode = MODE_STR;
                CH_SLASH:  p.mode = MODE_SLASH;
                CH_PLUS:   begin p.act = ACT_SINGLE; p.kind = K_PLUS;   end
                CH_MINUS:  begin p.act = ACT_SINGLE; p.kind = K_MINUS;  end
                CH_STAR:   begin p.act = ACT_SINGLE; p.kind = K_STAR;   end
                CH_LPAREN: begin p.act = ACT_SINGLE; p.kind = K_LPAREN; end
                CH_RPAREN: begin p.act = ACT_SINGLE; p.kind = K_RPAREN; end
                CH_SEMI:   begin p.act = ACT_SINGLE; p.kind = K_SC;     end
                CH_BANG:   begin p.act = ACT_SINGLE; p.kind = K_BANG;   end
                CH_DOT, CH_UNDER, CH_DOLLAR:
                           begin p.act = ACT_SINGLE; p.kind = K_ERR;    end
                CH_NL:     p.line_up = 1'b1;
                default:   p.line_up = 1'b0;
            endcase
        end
        return p;
    endfunction

    function automatic plan_t str_plan(input logic [7:0] c);
        plan_t p;
        p = plan_init();
        if (c == CH_QUOTE)
        begin
            p.act = ACT_EMIT; p.kind = K_STR; p.set_mode = 1'b1;
        end
        else if (c == CH_BSLASH)
        begin
            p.set_mode = 1'b1; p.mode = MODE_ESC;
        end
        else if (c == CH_NL)
        begin
            p.app = 1'b1; p.app_char = CH_NL; p.act = ACT_EMIT; p.kind = K_ERR;
            p.quote = 1'b1; p.set_mode = 1'b1;
        end
        else
        begin
            p.app = 1'b1; p.app_char = c;
        end
        return p;
    endfunction

    // What one decode step does: appends, clear, line count, mode change and the next sequencing action.
    always_comb
    begin
        plan = plan_init();
        unique case (state_reg)
            S_DECODE:
            begin
                if (cmd_reg)
                begin
                    plan.after = S_DONE;
                    plan.act   = ACT_EMIT;
                    unique case (mode_reg)
                        MODE_IDENT: plan.kind = stat.kw_kind;
                        MODE_INT:   plan.kind = K_INT;
                        MODE_ESC:
                        begin
                            plan.app = 1'b1; plan.app_char = CH_BSLASH;
                            plan.kind = K_ERR; plan.quote = 1'b1;
                        end
                        MODE_STR:   begin plan.kind = K_ERR; plan.quote = 1'b1; end
                        MODE_SLASH:
                        begin
                            plan.act = ACT_SINGLE; plan.kind = K_SLASH; plan.ch = CH_SLASH;
                        end
                        default:    plan.act = ACT_DONE;
                    endcase
                end
                else
                begin
                    unique case (mode_reg)
                        MODE_IDENT:
                        begin
                            if (is_letter(ch_reg) || is_digit(ch_reg))
                            begin
                                plan.app = 1'b1; plan.app_char = ch_reg;
                            end
                            else
                            begin
                                plan.act = ACT_EMIT; plan.kind = stat.kw_kind;
                                plan.after = S_BEGINC;
                            end
                        end
                        MODE_INT:
                        begin
                            if (is_digit(ch_reg))
                            begin
                                plan.app = 1'b1; plan.app_char = ch_reg;
                            end
                            else if (is_letter(ch_reg))
                            begin
                                plan.app = 1'b1; plan.app_char = ch_reg;
                                plan.act = ACT_EMIT; plan.kind = K_ERR; plan.set_mode = 1'b1;
                            end
                            else
                            begin
                                plan.act = ACT_EMIT; plan.kind = K_INT;
                                plan.after = S_BEGINC;
                            end
                        end
                        MODE_STR: plan = str_plan(ch_reg);
                        MODE_ESC:
                        begin
                            plan.set_mode = 1'b1;
                            plan.mode     = MODE_STR;
                            plan.app      = 1'b1;
                            if (is_esc_lit(ch_reg))
                            begin
                                plan.app_char = (ch_reg == CH_LOW_N) ? CH_NL : ch_reg;
                            end
                            else
                            begin
                                plan.app_char = CH_BSLASH;
                                plan.act      = ACT_STRC;
                            end
                        end
                        MODE_SLASH:
                        begin
                            if (ch_reg == CH_SLASH)
                            begin
                                plan.set_mode = 1'b1; plan.mode = MODE_COMMENT;
                            end
                            else
                            begin
                                plan.act = ACT_SINGLE; plan.kind = K_SLASH;
                                plan.ch = CH_SLASH; plan.after = S_BEGINC;
                            end
                        end
                        MODE_COMMENT:
                        begin
                            if (ch_reg == CH_NL)
                            begin
                                plan.line_up = 1'b1; plan.set_mode = 1'b1;
                            end
                        end
                        default: plan = begin_plan(ch_reg);
                    endcase
                end
            end
            S_STRC:   plan = str_plan(ch_reg);
            S_BEGINC: plan = begin_plan(ch_reg);
            default:  plan = plan_init();
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        after_next = after_reg;
        cmd_next   = cmd_reg;
        ch_next    = ch_reg;
        kind_next  = kind_reg;
        quote_next = quote_reg;
        sch_next   = sch_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = in_item.command;
                    ch_next    = in_item.char_in;
                    state_next = S_DECODE;
                end
            end
            S_DECODE, S_STRC, S_BEGINC:
            begin
                if (plan.set_mode)
                begin
                    mode_next = plan.mode;
                end
                kind_next  = plan.kind;
                quote_next = plan.quote;
                sch_next   = plan.ch;
                after_next = plan.after;
                unique case (plan.act)
                    ACT_EMIT:   state_next = S_EMIT;
                    ACT_SINGLE: state_next = S_SINGLE;
                    ACT_STRC:   state_next = S_STRC;
                    ACT_DONE:   state_next = S_DONE;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_EMIT:
            begin
                if (quote_reg)
                begin
                    state_next = S_QUOTE;
                end
                else if (stat.len_zero)
                begin
                    state_next = S_EMPTY;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_QUOTE:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.len_zero ? after_reg : S_RD;
                end
            end
            S_EMPTY, S_SINGLE:
            begin
                if (stat.out_free)
                begin
                    state_next = after_reg;
                end
            end
            S_RD: state_next = S_OUT;
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.rd_last ? after_reg : S_RD;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    mode_next  = MODE_BEGIN;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.out_kind = kind_reg;
        cmd.out_char = sch_reg;
        in_stall     = (state_reg != S_IDLE);
        unique case (state_reg)
            S_DECODE, S_STRC, S_BEGINC:
            begin
                cmd.app      = plan.app;
                cmd.app_char = plan.app_char;
                cmd.clr      = plan.clr;
                cmd.line_up  = plan.line_up;
            end
            S_EMIT: cmd.rd_clr = 1'b1;
            S_QUOTE:
            begin
                cmd.out_load  = stat.out_free;
                cmd.out_has   = 1'b1;
                cmd.out_char  = CH_QUOTE;
                cmd.out_last  = stat.len_zero;
                cmd.out_trunc = stat.ovf;
                cmd.clr       = stat.out_free && stat.len_zero;
            end
            S_EMPTY:
            begin
                cmd.out_load  = stat.out_free;
                cmd.out_last  = 1'b1;
                cmd.out_trunc = stat.ovf;
                cmd.clr       = stat.out_free;
            end
            S_OUT:
            begin
                cmd.out_load     = stat.out_free;
                cmd.out_has      = 1'b1;
                cmd.out_from_ram = 1'b1;
                cmd.out_last     = stat.rd_last;
                cmd.out_trunc    = stat.ovf;
                cmd.rd_inc       = stat.out_free;
                cmd.clr          = stat.out_free && stat.rd_last;
            end
            S_SINGLE:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_has  = 1'b1;
                cmd.out_last = 1'b1;
            end
            S_DONE:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_kind = K_DONE;
                cmd.out_last = 1'b1;
                cmd.clr      = stat.out_free;
            end
            default: cmd.clr = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= MODE_BEGIN;
            after_reg <= S_IDLE;
            quote_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            after_reg <= after_next;
            quote_reg <= quote_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        ch_reg   <= ch_next;
        kind_reg <= kind_next;
        sch_reg  <= sch_next;
    end

    a_out_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT |-> $past(state_reg) == S_RD || $past(state_reg) == S_OUT)
        else $error("buffer output without a read");
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE && in_valid |=> state_reg == S_DECODE)
        else $error("accepted item not decoded");
    a_after_target: assert property (@(posedge clk) disable iff (!rst_n)
        after_reg == S_IDLE || after_reg == S_BEGINC || after_reg == S_DONE)
        else $error("bad continuation after token");

endmodule

`default_nettype wire
